@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the command decoder RTL.
// No dependencies; the assertions compile out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_STD(lbl, prop, msg) `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_STD(lbl, prop, msg)
`endif
`endif

@@ rtl/core/sbocd_pkg.sv @@
// Package for the bulk-only SCSI command decoder: types, opcodes, reply tables.
// No dependencies; used by every module of the decoder.
package sbocd_pkg;

  localparam int unsigned BLOCK_BYTES_DEF = 512;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned OPCODE_W   = 8;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned XFER_W     = 25;
  localparam int unsigned RLEN_W     = 6;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned S_TDATA_W  = 88;
  localparam int unsigned M_TDATA_W  = 120;
  localparam int unsigned M_TUSER_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DISK_BLOCKS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_CARD  = 8'd1;
  localparam logic [ADDR_W-1:0]    DISK_BLOCKS_RST = 32'd2048;

  localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
  localparam logic [7:0] OP_REQUEST_SENSE   = 8'h03;
  localparam logic [7:0] OP_INQUIRY         = 8'h12;
  localparam logic [7:0] OP_MODE_SENSE6     = 8'h1A;
  localparam logic [7:0] OP_START_STOP      = 8'h1B;
  localparam logic [7:0] OP_PREVENT_ALLOW   = 8'h1E;
  localparam logic [7:0] OP_READ_CAPACITY10 = 8'h25;
  localparam logic [7:0] OP_READ10          = 8'h28;
  localparam logic [7:0] OP_WRITE10         = 8'h2A;
  localparam logic [7:0] OP_SYNC_CACHE10    = 8'h35;
  localparam logic [7:0] OP_MODE_SENSE10    = 8'h5A;

  localparam logic [7:0] SK_ILLEGAL_REQUEST = 8'h05;
  localparam logic [7:0] ASC_BAD_OPCODE     = 8'h20;
  localparam logic [7:0] ASC_BAD_LBA        = 8'h21;
  localparam logic [7:0] SENSE_FIXED_FORMAT = 8'h70;
  localparam logic [7:0] SENSE_ADD_LEN      = 8'd10;
  localparam logic [7:0] MODE6_DATA_LEN     = 8'd3;
  localparam logic [7:0] MODE10_DATA_LEN    = 8'd6;

  localparam logic [RLEN_W-1:0] LEN_INQUIRY  = 6'd36;
  localparam logic [RLEN_W-1:0] LEN_SENSE    = 6'd18;
  localparam logic [RLEN_W-1:0] LEN_CAPACITY = 6'd8;
  localparam logic [RLEN_W-1:0] LEN_MODE6    = 6'd4;
  localparam logic [RLEN_W-1:0] LEN_MODE10   = 6'd8;

  localparam logic [7:0] INQUIRY_DATA [36] = '{
    8'h00, 8'h80, 8'h04, 8'h02, 8'h1F, 8'h00, 8'h00, 8'h00,
    8'h54, 8'h69, 8'h6B, 8'h75, 8'h4F, 8'h53, 8'h20, 8'h20,
    8'h52, 8'h41, 8'h4D, 8'h20, 8'h44, 8'h69, 8'h73, 8'h6B,
    8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
    8'h30, 8'h2E, 8'h30, 8'h36
  };

  localparam logic [7:0] FLASH_PRODUCT [16] = '{
    8'h65, 8'h4D, 8'h4D, 8'h43, 8'h20, 8'h38, 8'h47, 8'h42,
    8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20
  };

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_REPLY = 2'd1,
    ACT_READ  = 2'd2,
    ACT_WRITE = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    CMD_NODATA,
    CMD_READ,
    CMD_WRITE,
    CMD_BAD_RANGE,
    CMD_UNKNOWN,
    CMD_INQUIRY,
    CMD_SENSE,
    CMD_CAPACITY,
    CMD_MODE6,
    CMD_MODE10
  } cmd_kind_e;

  typedef struct packed {
    logic [ADDR_W-1:0]   host;
    logic [COUNT_W-1:0]  nblk;
    logic [ADDR_W-1:0]   lba;
    logic [OPCODE_W-1:0] opcode;
  } cmd_t;

  typedef struct packed {
    action_e             action;
    cmd_kind_e           kind;
    logic [ADDR_W-1:0]   addr;
    logic [COUNT_W-1:0]  count;
    logic [XFER_W-1:0]   xfer;
    logic [ADDR_W-1:0]   residue;
    logic                fail;
    logic [RLEN_W-1:0]   rlen;
    logic                flash;
    logic [7:0]          skey;
    logic [7:0]          scode;
    logic [ADDR_W-1:0]   last_lba;
  } desc_t;

  function automatic logic [7:0] reply_byte(cmd_kind_e kind, logic [RLEN_W-1:0] idx,
                                            logic flash, logic [7:0] skey,
                                            logic [7:0] scode, logic [31:0] last_lba,
                                            logic [31:0] blk);
    logic [7:0] b;
    b = 8'h00;
    case (kind)
      CMD_INQUIRY: begin
        if (flash && idx[5:4] == 2'b01) begin
          b = FLASH_PRODUCT[idx[3:0]];
        end else if (idx < LEN_INQUIRY) begin
          b = INQUIRY_DATA[idx];
        end
      end
      CMD_SENSE: begin
        case (idx)
          6'd0:    b = SENSE_FIXED_FORMAT;
          6'd2:    b = skey;
          6'd7:    b = SENSE_ADD_LEN;
          6'd12:   b = scode;
          default: b = 8'h00;
        endcase
      end
      CMD_CAPACITY: begin
        case (idx)
          6'd0:    b = last_lba[31:24];
          6'd1:    b = last_lba[23:16];
          6'd2:    b = last_lba[15:8];
          6'd3:    b = last_lba[7:0];
          6'd4:    b = blk[31:24];
          6'd5:    b = blk[23:16];
          6'd6:    b = blk[15:8];
          6'd7:    b = blk[7:0];
          default: b = 8'h00;
        endcase
      end
      CMD_MODE6: begin
        if (idx == 6'd0) b = MODE6_DATA_LEN;
      end
      CMD_MODE10: begin
        if (idx == 6'd1) b = MODE10_DATA_LEN;
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/core/sbocd_queue.sv @@
// Descriptor queue between the decoder front end and the reply streamer.
// Depends on sbocd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sbocd_queue #(
  parameter int unsigned DEPTH = sbocd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sbocd_pkg::desc_t push_desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output sbocd_pkg::desc_t head_o
);
  import sbocd_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  desc_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  `ASSERT_STD(a_no_push_when_full, push_i |-> !full_o, "push into a full queue")
  `ASSERT_STD(a_count_bound, count_q <= CntFull, "queue count beyond depth")

endmodule

@@ rtl/core/sbocd_front.sv @@
// Decoder front end: command intake, classification, range check, sense store.
// Depends on sbocd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sbocd_front #(
  parameter int unsigned BLOCK_BYTES = sbocd_pkg::BLOCK_BYTES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [sbocd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sbocd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  sbocd_pkg::cmd_t                     in_cmd_i,
  output logic                                push_o,
  input  logic                                full_i,
  output sbocd_pkg::desc_t                    desc_o
);
  import sbocd_pkg::*;

  localparam int unsigned BbW   = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned ProdW = COUNT_W + BbW;
  localparam int unsigned CmpW  = (ProdW > ADDR_W) ? ProdW : ADDR_W;

  logic [ADDR_W-1:0] disk_q;
  logic              flash_q;
  logic [7:0]        skey_q, skey_d;
  logic [7:0]        scode_q, scode_d;

  logic              s1_valid_q, s1_valid_d;
  cmd_kind_e         s1_kind_q;
  logic [ADDR_W-1:0] s1_lba_q;
  logic [COUNT_W-1:0] s1_nblk_q;
  logic [ADDR_W-1:0] s1_host_q;
  logic [ProdW-1:0]  s1_prod_q;
  logic [7:0]        s1_skey_q, s1_scode_q;
  logic              s1_flash_q;
  logic [ADDR_W-1:0] s1_last_lba_q;

  logic              in_fire;
  logic [ADDR_W-1:0] room;
  logic              range_ok;
  cmd_kind_e         kind;
  logic [CmpW-1:0]   bytes;
  logic [RLEN_W-1:0] full_len;
  logic [RLEN_W-1:0] cap_len;

  assign in_ready_o = !s1_valid_q || !full_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign push_o     = s1_valid_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_q  <= DISK_BLOCKS_RST;
      flash_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_DISK_BLOCKS) begin
        disk_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_FLASH_CARD) begin
        flash_q <= cfg_data_i[0];
      end
    end
  end

  assign room     = disk_q - in_cmd_i.lba;
  assign range_ok = (in_cmd_i.nblk == '0) ||
                    ((in_cmd_i.lba < disk_q) && (ADDR_W'(in_cmd_i.nblk) <= room));

  always_comb begin
    case (in_cmd_i.opcode)
      OP_READ10:          kind = range_ok ? CMD_READ : CMD_BAD_RANGE;
      OP_WRITE10:         kind = range_ok ? CMD_WRITE : CMD_BAD_RANGE;
      OP_TEST_UNIT_READY,
      OP_START_STOP,
      OP_PREVENT_ALLOW,
      OP_SYNC_CACHE10:    kind = CMD_NODATA;
      OP_INQUIRY:         kind = CMD_INQUIRY;
      OP_REQUEST_SENSE:   kind = CMD_SENSE;
      OP_READ_CAPACITY10: kind = CMD_CAPACITY;
      OP_MODE_SENSE6:     kind = CMD_MODE6;
      OP_MODE_SENSE10:    kind = CMD_MODE10;
      default:            kind = CMD_UNKNOWN;
    endcase
  end

  always_comb begin
    skey_d     = skey_q;
    scode_d    = scode_q;
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
      case (kind)
        CMD_BAD_RANGE: begin
          skey_d  = SK_ILLEGAL_REQUEST;
          scode_d = ASC_BAD_LBA;
        end
        CMD_UNKNOWN: begin
          skey_d  = SK_ILLEGAL_REQUEST;
          scode_d = ASC_BAD_OPCODE;
        end
        CMD_SENSE: begin
          skey_d  = '0;
          scode_d = '0;
        end
        default: begin
          skey_d  = skey_q;
          scode_d = scode_q;
        end
      endcase
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      skey_q     <= '0;
      scode_q    <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      skey_q     <= skey_d;
      scode_q    <= scode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q     <= kind;
      s1_lba_q      <= in_cmd_i.lba;
      s1_nblk_q     <= in_cmd_i.nblk;
      s1_host_q     <= in_cmd_i.host;
      s1_prod_q     <= ProdW'(in_cmd_i.nblk) * ProdW'(BLOCK_BYTES);
      s1_skey_q     <= skey_q;
      s1_scode_q    <= scode_q;
      s1_flash_q    <= flash_q;
      s1_last_lba_q <= disk_q - 1'b1;
    end
  end

  assign bytes = (CmpW'(s1_prod_q) > CmpW'(s1_host_q)) ? CmpW'(s1_host_q) : CmpW'(s1_prod_q);

  always_comb begin
    case (s1_kind_q)
      CMD_INQUIRY:  full_len = LEN_INQUIRY;
      CMD_SENSE:    full_len = LEN_SENSE;
      CMD_CAPACITY: full_len = LEN_CAPACITY;
      CMD_MODE6:    full_len = LEN_MODE6;
      CMD_MODE10:   full_len = LEN_MODE10;
      default:      full_len = '0;
    endcase
  end

  assign cap_len = (s1_host_q < ADDR_W'(full_len)) ? s1_host_q[RLEN_W-1:0] : full_len;

  always_comb begin
    desc_o          = '0;
    desc_o.action   = ACT_NONE;
    desc_o.kind     = s1_kind_q;
    desc_o.residue  = s1_host_q;
    desc_o.flash    = s1_flash_q;
    desc_o.skey     = s1_skey_q;
    desc_o.scode    = s1_scode_q;
    desc_o.last_lba = s1_last_lba_q;
    case (s1_kind_q)
      CMD_READ, CMD_WRITE: begin
        desc_o.action  = (s1_kind_q == CMD_READ) ? ACT_READ : ACT_WRITE;
        desc_o.addr    = s1_lba_q;
        desc_o.count   = s1_nblk_q;
        desc_o.xfer    = bytes[XFER_W-1:0];
        desc_o.residue = s1_host_q - bytes[ADDR_W-1:0];
      end
      CMD_BAD_RANGE, CMD_UNKNOWN: begin
        desc_o.fail = 1'b1;
      end
      CMD_INQUIRY, CMD_SENSE, CMD_CAPACITY, CMD_MODE6, CMD_MODE10: begin
        if (cap_len != '0) begin
          desc_o.action  = ACT_REPLY;
          desc_o.xfer    = XFER_W'(cap_len);
          desc_o.residue = s1_host_q - ADDR_W'(cap_len);
          desc_o.rlen    = cap_len;
        end
      end
      default: begin
        desc_o.fail = 1'b0;
      end
    endcase
  end

  `ASSERT_STD(a_bad_range_sense,
    (in_fire && kind == CMD_BAD_RANGE) |=>
      (skey_q == SK_ILLEGAL_REQUEST && scode_q == ASC_BAD_LBA),
    "bad range left no sense")
  `ASSERT_STD(a_fail_no_action,
    (s1_valid_q && desc_o.fail) |-> (desc_o.action == ACT_NONE),
    "failed command carries an action")

endmodule

@@ rtl/core/sbocd_back.sv @@
// Reply streamer: turns queued descriptors into result transactions, one per cycle
// while the output is not stalled. Depends on sbocd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sbocd_back #(
  parameter int unsigned BLOCK_BYTES = sbocd_pkg::BLOCK_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             head_valid_i,
  input  sbocd_pkg::desc_t                 head_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output sbocd_pkg::action_e               out_action_o,
  output logic [sbocd_pkg::ADDR_W-1:0]     out_addr_o,
  output logic [sbocd_pkg::COUNT_W-1:0]    out_count_o,
  output logic [sbocd_pkg::XFER_W-1:0]     out_xfer_o,
  output logic [sbocd_pkg::ADDR_W-1:0]     out_residue_o,
  output logic                             out_fail_o,
  output logic [sbocd_pkg::RLEN_W-1:0]     out_rlen_o,
  output logic [7:0]                       out_byte_o,
  output logic                             out_last_o
);
  import sbocd_pkg::*;

  localparam logic [31:0] BlkBytes = 32'(BLOCK_BYTES);

  logic              m_valid_q, m_valid_d;
  action_e           m_action_q;
  logic [ADDR_W-1:0] m_addr_q;
  logic [COUNT_W-1:0] m_count_q;
  logic [XFER_W-1:0] m_xfer_q;
  logic [ADDR_W-1:0] m_residue_q;
  logic              m_fail_q;
  logic [RLEN_W-1:0] m_rlen_q;
  logic [7:0]        m_byte_q;
  logic              m_last_q;
  logic [RLEN_W-1:0] idx_q, idx_d;

  logic              advance, load, is_reply, last_item;
  logic [7:0]        next_byte;

  assign advance   = !m_valid_q || out_ready_i;
  assign load      = advance && head_valid_i;
  assign is_reply  = (head_i.action == ACT_REPLY);
  assign last_item = !is_reply || (idx_q == head_i.rlen - 1'b1);
  assign pop_o     = load && last_item;
  assign next_byte = is_reply ? reply_byte(head_i.kind, idx_q, head_i.flash, head_i.skey,
                                           head_i.scode, head_i.last_lba, BlkBytes)
                              : 8'h00;

  always_comb begin
    m_valid_d = m_valid_q;
    idx_d     = idx_q;
    if (advance) begin
      m_valid_d = head_valid_i;
    end
    if (load) begin
      idx_d = last_item ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      m_valid_q <= m_valid_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_action_q  <= head_i.action;
      m_addr_q    <= head_i.addr;
      m_count_q   <= head_i.count;
      m_xfer_q    <= head_i.xfer;
      m_residue_q <= head_i.residue;
      m_fail_q    <= head_i.fail;
      m_rlen_q    <= head_i.rlen;
      m_byte_q    <= next_byte;
      m_last_q    <= last_item;
    end
  end

  assign out_valid_o   = m_valid_q;
  assign out_action_o  = m_action_q;
  assign out_addr_o    = m_addr_q;
  assign out_count_o   = m_count_q;
  assign out_xfer_o    = m_xfer_q;
  assign out_residue_o = m_residue_q;
  assign out_fail_o    = m_fail_q;
  assign out_rlen_o    = m_rlen_q;
  assign out_byte_o    = m_byte_q;
  assign out_last_o    = m_last_q;

  `ASSERT_STD(a_only_reply_continues,
    (m_valid_q && !m_last_q) |-> (m_action_q == ACT_REPLY),
    "non-reply transaction without last")
  `ASSERT_STD(a_reply_has_length,
    (m_valid_q && m_action_q == ACT_REPLY) |-> (m_rlen_q != '0),
    "reply transaction with zero length")

endmodule

@@ rtl/core/scsi_bulk_only_command_decoder.sv @@
// Channel    Dir  Handshake             Payload
// s_axis     in   tvalid/tready         command: opcode, LBA, block count, host length
// m_axis     out  tvalid/tready         result: action, transfer fields, reply byte, tlast
// cfg        in   cfg_valid/cfg_ready   register index and write data
//
// A command is classified on intake; its results pass the queue and output register.
// Reply commands stream one byte per cycle, up to 36 bytes each, set by the reply length.
// Other commands give one result transaction per cycle; m_axis backpressure stalls both.
// The front end takes commands while the queue has room or its stage register is empty.
// Reset clears the sense data and restores disk_blocks to 2048; no clearing pass.
// Top level of the bulk-only SCSI command decoder. Depends on sbocd_pkg,
// sbocd_front, sbocd_queue and sbocd_back.
module scsi_bulk_only_command_decoder #(
  parameter int unsigned BLOCK_BYTES = sbocd_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH = sbocd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sbocd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sbocd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // opcode[7:0], block_address[39:8], block_count[55:40], host_length[87:56]
  input  logic [sbocd_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_address[31:0], out_count[47:32], transfer_bytes[72:48], residue[104:73],
  // fail_status[105], reply_length[111:106], reply_byte[119:112]
  output logic [sbocd_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // action[1:0]
  output logic [sbocd_pkg::M_TUSER_W-1:0]     m_axis_tuser,
  output logic                                m_axis_tlast
);
  import sbocd_pkg::*;

  cmd_t              cmd;
  desc_t             push_desc, head_desc;
  logic              push, full, pop, head_valid;
  action_e           out_action;
  logic [ADDR_W-1:0] out_addr;
  logic [COUNT_W-1:0] out_count;
  logic [XFER_W-1:0] out_xfer;
  logic [ADDR_W-1:0] out_residue;
  logic              out_fail;
  logic [RLEN_W-1:0] out_rlen;
  logic [7:0]        out_byte;

  assign cfg_ready_o = 1'b1;

  assign cmd.opcode = s_axis_tdata[7:0];
  assign cmd.lba    = s_axis_tdata[39:8];
  assign cmd.nblk   = s_axis_tdata[55:40];
  assign cmd.host   = s_axis_tdata[87:56];

  sbocd_front #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (cmd),
    .push_o      (push),
    .full_i      (full),
    .desc_o      (push_desc)
  );

  sbocd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head_desc)
  );

  sbocd_back #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head_desc),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_action_o  (out_action),
    .out_addr_o    (out_addr),
    .out_count_o   (out_count),
    .out_xfer_o    (out_xfer),
    .out_residue_o (out_residue),
    .out_fail_o    (out_fail),
    .out_rlen_o    (out_rlen),
    .out_byte_o    (out_byte),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {out_byte, out_rlen, out_fail, out_residue, out_xfer,
                         out_count, out_addr};
  assign m_axis_tuser = out_action;

endmodule

@@ test/scsi_bulk_only_command_decoder_tb.sv @@
// Self-checking bench for scsi_bulk_only_command_decoder: random and directed SCSI commands
// in, every result transaction checked against a local decision model of the transport.
// Depends on sbocd_pkg and the decoder RTL.
module scsi_bulk_only_command_decoder_tb;
  import sbocd_pkg::*;

  localparam int unsigned BLOCK_BYTES      = BLOCK_BYTES_DEF;
  localparam int unsigned SINK_HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned END_CYCLES       = 40;
  localparam int unsigned TIMEOUT_TIME     = 36_000_000;
  localparam int unsigned MAX_PRINTS       = 100;

  // standard identification data, vendor text given as raw bytes
  localparam logic [287:0] IDENT_BYTES = {
    8'h00, 8'h80, 8'h04, 8'h02, 8'h1F, 8'h00, 8'h00, 8'h00,
    64'h5469_6B75_4F53_2020, "RAM Disk", "        ", "0.06"
  };
  localparam logic [127:0] FLASH_TEXT = {"eMMC 8GB", "        "};

  typedef struct packed {
    action_e              action;
    logic [ADDR_W-1:0]    addr;
    logic [COUNT_W-1:0]   count;
    logic [XFER_W-1:0]    xfer;
    logic [31:0]          residue;
    logic                 fail;
    logic [RLEN_W-1:0]    rlen;
    logic [7:0]           rbyte;
    logic                 last;
  } xfer_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [M_TUSER_W-1:0]  m_axis_tuser;
  logic                  m_axis_tlast;

  xfer_result_t xfer_result_q [$];
  logic [31:0]  disk_blocks_m = DISK_BLOCKS_RST;
  logic         flash_m = 1'b0;
  logic [7:0]   sense_key_m = 8'h00;
  logic [7:0]   sense_code_m = 8'h00;
  int unsigned  error_count = 0;
  int unsigned  results_seen = 0;
  logic         idle_gaps_on = 1'b1;
  int unsigned  hold_requests = 0;
  int unsigned  hold_served = 0;
  int unsigned  hold_left = 0;
  int unsigned  sink_gap = 0;

  scsi_bulk_only_command_decoder #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_PRINTS) begin
      $display("mismatch in result %0d, %0s: got 0x%0h, want 0x%0h",
               results_seen, what, got, want);
    end
    error_count++;
  endtask

  task automatic decide_transport(input logic [7:0] op, input logic [31:0] lba,
                                  input logic [15:0] nblk, input logic [31:0] host);
    xfer_result_t res;
    logic [7:0]   rb [36];
    int unsigned  len;
    logic [63:0]  bytes;
    logic [31:0]  cap_last;
    logic         in_range;
    logic         known;
    int           i;
    res = '0;
    res.action = ACT_NONE;
    len = 0;
    known = 1'b1;
    for (i = 0; i < 36; i++) rb[i] = 8'h00;
    if (op == OP_READ10 || op == OP_WRITE10) begin
      if (nblk == 16'h0) in_range = 1'b1;
      else if (lba >= disk_blocks_m) in_range = 1'b0;
      else in_range = ({16'h0, nblk} <= disk_blocks_m - lba);
      res.last = 1'b1;
      if (!in_range) begin
        sense_key_m  = SK_ILLEGAL_REQUEST;
        sense_code_m = ASC_BAD_LBA;
        res.residue  = host;
        res.fail     = 1'b1;
      end else begin
        bytes = 64'(nblk) * 64'(BLOCK_BYTES);
        if (bytes > {32'h0, host}) bytes = {32'h0, host};
        res.action  = (op == OP_READ10) ? ACT_READ : ACT_WRITE;
        res.addr    = lba;
        res.count   = nblk;
        res.xfer    = bytes[XFER_W-1:0];
        res.residue = host - bytes[31:0];
      end
      xfer_result_q.push_back(res);
    end else begin
      case (op)
        OP_TEST_UNIT_READY, OP_START_STOP, OP_PREVENT_ALLOW, OP_SYNC_CACHE10: begin
          len = 0;
        end
        OP_INQUIRY: begin
          for (i = 0; i < 36; i++) rb[i] = IDENT_BYTES[287 - 8*i -: 8];
          if (flash_m) begin
            for (i = 0; i < 16; i++) rb[16 + i] = FLASH_TEXT[127 - 8*i -: 8];
          end
          len = 36;
        end
        OP_REQUEST_SENSE: begin
          rb[0]  = SENSE_FIXED_FORMAT;
          rb[2]  = sense_key_m;
          rb[7]  = SENSE_ADD_LEN;
          rb[12] = sense_code_m;
          sense_key_m  = 8'h00;
          sense_code_m = 8'h00;
          len = 18;
        end
        OP_READ_CAPACITY10: begin
          cap_last = disk_blocks_m - 32'd1;
          for (i = 0; i < 4; i++) begin
            rb[i]     = cap_last[31 - 8*i -: 8];
            rb[4 + i] = 8'(BLOCK_BYTES >> (24 - 8*i));
          end
          len = 8;
        end
        OP_MODE_SENSE6: begin
          rb[0] = MODE6_DATA_LEN;
          len = 4;
        end
        OP_MODE_SENSE10: begin
          rb[1] = MODE10_DATA_LEN;
          len = 8;
        end
        default: known = 1'b0;
      endcase
      if (!known) begin
        sense_key_m  = SK_ILLEGAL_REQUEST;
        sense_code_m = ASC_BAD_OPCODE;
        res.residue  = host;
        res.fail     = 1'b1;
        res.last     = 1'b1;
        xfer_result_q.push_back(res);
      end else begin
        if (len > host) len = host;
        if (len == 0) begin
          res.residue = host;
          res.last    = 1'b1;
          xfer_result_q.push_back(res);
        end else begin
          for (i = 0; i < int'(len); i++) begin
            res.action  = ACT_REPLY;
            res.xfer    = XFER_W'(len);
            res.residue = host - len;
            res.rlen    = RLEN_W'(len);
            res.rbyte   = rb[i];
            res.last    = (i == int'(len) - 1);
            xfer_result_q.push_back(res);
          end
        end
      end
    end
  endtask

  task automatic send_command(input logic [7:0] op, input logic [31:0] lba,
                              input logic [15:0] nblk, input logic [31:0] host);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {host, nblk, lba, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decide_transport(op, lba, nblk, host);
    gap = idle_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (xfer_result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_DISK_BLOCKS) disk_blocks_m = value;
    else if (idx == CFG_FLASH_CARD) flash_m = value[0];
    repeat (2) @(posedge clk_i);
  endtask

  task automatic send_random_command();
    logic [7:0]  op;
    logic [31:0] lba;
    logic [15:0] nblk;
    logic [31:0] host;
    logic [31:0] full_bytes;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      op = $urandom_range(0, 1) ? OP_READ10 : OP_WRITE10;
    end else if (roll < 85) begin
      case ($urandom_range(0, 8))
        0:       op = OP_TEST_UNIT_READY;
        1:       op = OP_START_STOP;
        2:       op = OP_PREVENT_ALLOW;
        3:       op = OP_SYNC_CACHE10;
        4:       op = OP_INQUIRY;
        5:       op = OP_REQUEST_SENSE;
        6:       op = OP_READ_CAPACITY10;
        7:       op = OP_MODE_SENSE6;
        default: op = OP_MODE_SENSE10;
      endcase
    end else begin
      op = 8'($urandom);
    end
    case ($urandom_range(0, 5))
      0:       nblk = 16'h0;
      1:       nblk = 16'h1;
      2:       nblk = 16'($urandom_range(1, 64));
      3:       nblk = 16'($urandom);
      4:       nblk = 16'hFFFF;
      default: nblk = 16'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 5))
      0:       lba = $urandom;
      1:       lba = 32'h0;
      2:       lba = disk_blocks_m - {16'h0, nblk};
      3:       lba = disk_blocks_m - {16'h0, nblk} + 32'd1;
      4:       lba = (disk_blocks_m == 32'h0) ? 32'h0 : $urandom % disk_blocks_m;
      default: lba = disk_blocks_m;
    endcase
    full_bytes = {16'h0, nblk} * BLOCK_BYTES;
    case ($urandom_range(0, 5))
      0:       host = 32'h0;
      1:       host = $urandom_range(1, 40);
      2:       host = full_bytes;
      3:       host = full_bytes - $urandom_range(1, 600);
      4:       host = $urandom;
      default: host = 32'hFFFF_FFFF;
    endcase
    send_command(op, lba, nblk, host);
  endtask

  task automatic test_directed_commands();
    idle_gaps_on <= 1'b1;
    send_command(OP_TEST_UNIT_READY, 32'h0, 16'h0, 32'h0);
    send_command(OP_START_STOP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_command(OP_PREVENT_ALLOW, 32'h0, 16'h0, 32'd5);
    send_command(OP_SYNC_CACHE10, 32'h1234_5678, 16'h8, 32'h0);
    send_command(OP_INQUIRY, 32'h0, 16'h0, 32'hFFFF_FFFF);
    send_command(OP_INQUIRY, 32'h0, 16'h0, 32'd5);
    send_command(OP_INQUIRY, 32'h0, 16'h0, 32'h0);
    send_command(OP_READ_CAPACITY10, 32'h0, 16'h0, 32'd8);
    send_command(OP_MODE_SENSE6, 32'h0, 16'h0, 32'd255);
    send_command(OP_MODE_SENSE10, 32'h0, 16'h0, 32'd3);
    send_command(OP_REQUEST_SENSE, 32'h0, 16'h0, 32'd18);
    send_command(8'hFF, 32'h0, 16'h0, 32'd100);
    send_command(OP_REQUEST_SENSE, 32'h0, 16'h0, 32'hFFFF_FFFF);
    send_command(OP_READ10, 32'h0, 16'd2048, 32'hFFFF_FFFF);
    send_command(OP_READ10, 32'd2047, 16'd2, 32'd1024);
    send_command(OP_REQUEST_SENSE, 32'h0, 16'h0, 32'd13);
    send_command(OP_WRITE10, 32'hFFFF_FFFF, 16'h0, 32'd1234);
    send_command(OP_WRITE10, 32'd100, 16'd16, 32'd1000);
    send_command(OP_READ10, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_command(8'h01, 32'h0, 16'h0, 32'h0);
    send_command(OP_REQUEST_SENSE, 32'h0, 16'h0, 32'h0);
    send_command(OP_REQUEST_SENSE, 32'h0, 16'h0, 32'd18);
  endtask

  task automatic test_register_extremes();
    write_register(CFG_DISK_BLOCKS, 32'h0);
    send_command(OP_READ_CAPACITY10, 32'h0, 16'h0, 32'd8);
    send_command(OP_READ10, 32'h0, 16'h1, 32'd512);
    send_command(OP_READ10, 32'h0, 16'h0, 32'd512);
    send_command(OP_REQUEST_SENSE, 32'h0, 16'h0, 32'd18);
    write_register(CFG_DISK_BLOCKS, 32'hFFFF_FFFF);
    write_register(CFG_FLASH_CARD, 32'hFFFF_FFFF);
    send_command(OP_READ_CAPACITY10, 32'h0, 16'h0, 32'd8);
    send_command(OP_INQUIRY, 32'h0, 16'h0, 32'd36);
    send_command(OP_READ10, 32'hFFFF_FFFE, 16'h1, 32'hFFFF_FFFF);
    send_command(OP_WRITE10, 32'hFFFF_FFFE, 16'h2, 32'hFFFF_FFFF);
    send_command(OP_READ10, 32'h0, 16'hFFFF, 32'hFFFF_FFFF);
    write_register(CFG_FLASH_CARD, 32'hFFFF_FFFE);
    send_command(OP_INQUIRY, 32'h0, 16'h0, 32'd40);
    write_register(CFG_DISK_BLOCKS, 32'h1);
    send_command(OP_READ10, 32'h0, 16'h1, 32'd600);
    send_command(OP_WRITE10, 32'h1, 16'h1, 32'd512);
  endtask

  task automatic test_output_backpressure();
    int i;
    drain_results();
    hold_requests <= hold_requests + 1;
    for (i = 0; i < 24; i++) begin
      if (i % 3 == 0) send_command(OP_INQUIRY, 32'h0, 16'h0, 32'hFFFF_FFFF);
      else send_random_command();
    end
    drain_results();
  endtask

  task automatic test_random_commands();
    int          phase;
    logic [31:0] disk;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       disk = DISK_BLOCKS_RST;
        1:       disk = $urandom_range(1, 64);
        2:       disk = 32'hFFFF_FFFF;
        3:       disk = $urandom;
        4:       disk = 32'h1;
        default: disk = $urandom_range(100, 5000);
      endcase
      write_register(CFG_DISK_BLOCKS, disk);
      write_register(CFG_FLASH_CARD, {31'($urandom), phase[0]});
      idle_gaps_on <= (phase != 2);
      repeat (55) send_random_command();
    end
    idle_gaps_on <= 1'b1;
  endtask

  always @(posedge clk_i) begin : sink_pacing
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = SINK_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_gaps_on) sink_gap = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    xfer_result_t got;
    xfer_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.action  = action_e'(m_axis_tuser);
      got.addr    = m_axis_tdata[31:0];
      got.count   = m_axis_tdata[47:32];
      got.xfer    = m_axis_tdata[72:48];
      got.residue = m_axis_tdata[104:73];
      got.fail    = m_axis_tdata[105];
      got.rlen    = m_axis_tdata[111:106];
      got.rbyte   = m_axis_tdata[119:112];
      got.last    = m_axis_tlast;
      if (xfer_result_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(got.action), 32'h0);
      end else begin
        want = xfer_result_q.pop_front();
        if (got.action != want.action) report_mismatch("action", got.action, want.action);
        if (got.addr != want.addr) report_mismatch("out_address", got.addr, want.addr);
        if (got.count != want.count) report_mismatch("out_count", got.count, want.count);
        if (got.xfer != want.xfer) report_mismatch("transfer_bytes", got.xfer, want.xfer);
        if (got.residue != want.residue) report_mismatch("residue", got.residue, want.residue);
        if (got.fail != want.fail) report_mismatch("fail_status", got.fail, want.fail);
        if (got.rlen != want.rlen) report_mismatch("reply_length", got.rlen, want.rlen);
        if (got.rbyte != want.rbyte) report_mismatch("reply_byte", got.rbyte, want.rbyte);
        if (got.last != want.last) report_mismatch("last", got.last, want.last);
      end
      results_seen++;
    end
  end

  initial begin : watchdog
    #(TIMEOUT_TIME);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : run_regression
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_commands();
    test_register_extremes();
    test_output_backpressure();
    test_random_commands();
    drain_results();
    repeat (END_CYCLES) @(posedge clk_i);
    if (error_count == 0 && xfer_result_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/sbocd_pkg.sv
rtl/core/sbocd_queue.sv
rtl/core/sbocd_front.sv
rtl/core/sbocd_back.sv
rtl/core/scsi_bulk_only_command_decoder.sv
test/scsi_bulk_only_command_decoder_tb.sv
